FILE: rtl/bss_pkg.sv
// Shared types and constants of the byte signature scanner.
// Holds the signature table and the step word passed to the window. No dependencies.
package bss_pkg;

    localparam int SIG_COUNT  = 8;
    localparam int SIG_MAXLEN = 9;

    // One signature, byte 0 is the final byte of the signature, byte 1 the one before it.
    typedef logic [SIG_MAXLEN-1:0][7:0] sig_row_t;
    typedef logic [3:0]                 sig_len_t;

    // Written in message order, left-padded with zero.
    localparam sig_row_t SIG_REV [SIG_COUNT] = '{
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h25, 8'h50, 8'h44, 8'h46, 8'h2D}, // %PDF-
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 8'h4B, 8'h03, 8'h04}, // PK 03 04
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h7A, 8'h58, 8'h5A}, // 7zXZ
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h52, 8'h61, 8'h72, 8'h21}, // Rar!
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C}, // <?xml
        {8'h3C, 8'h21, 8'h44, 8'h4F, 8'h43, 8'h54, 8'h59, 8'h50, 8'h45}, // <!DOCTYPE
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4D, 8'h5A}, // MZ
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h4C, 8'h46}  // ELF
    };

    localparam sig_len_t SIG_LEN [SIG_COUNT] = '{
        4'd5, 4'd4, 4'd4, 4'd4, 4'd5, 4'd9, 4'd2, 4'd3
    };

    // One byte handed from the input register to the window.
    typedef struct packed {
        logic       take;
        logic       last;
        logic [7:0] data;
    } bss_step_t;

endpackage

FILE: rtl/bss_if.sv
// Channel interfaces of the byte signature scanner.
// Byte channel and result channel with valid/ready handshake. No dependencies.
interface bss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface bss_out_if;
    logic       valid;
    logic       ready;
    logic       suspicious;
    logic [7:0] found_mask;

    modport source (output valid, suspicious, found_mask, input ready);
    modport sink   (input valid, suspicious, found_mask, output ready);
endinterface

FILE: rtl/bss_match.sv
// Parallel compare of the current byte and the history window against all signatures.
// Depends on bss_pkg for the signature table.
module bss_match #(
    parameter int HISTORY_BYTES = 8,
    parameter int FW            = 4
) (
    input  logic [7:0]                   cur,
    input  logic [7:0]                   hist [HISTORY_BYTES],
    input  logic [FW-1:0]                fill,
    output logic [bss_pkg::SIG_COUNT-1:0] hit
);
    import bss_pkg::*;

    localparam int CW = (FW > 4) ? FW : 4;

    logic [CW-1:0] fill_w;

    assign fill_w = CW'(fill);

    // A signature hits when it ends on the current byte and lies wholly inside this message
    always_comb
    begin
        for (int i = 0; i < SIG_COUNT; i++)
        begin
            hit[i] = (cur == SIG_REV[i][0]) &&
                     (fill_w >= (CW'(SIG_LEN[i]) - CW'(1)));
            for (int k = 0; k < SIG_MAXLEN - 1; k++)
            begin
                if ((k + 1) < int'(SIG_LEN[i]))
                begin
                    hit[i] = hit[i] && (hist[k] == SIG_REV[i][k+1]);
                end
            end
        end
    end

endmodule

FILE: rtl/bss_window.sv
// History window, fill count and sticky mask of one message.
// Depends on bss_pkg and bss_match.
module bss_window #(
    parameter int HISTORY_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bss_pkg::bss_step_t            step,
    output logic [bss_pkg::SIG_COUNT-1:0] found
);
    import bss_pkg::*;

    localparam int FW = $clog2(HISTORY_BYTES + 1);

    logic [7:0]           hist_reg [HISTORY_BYTES];
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;
    logic [SIG_COUNT-1:0] seen_reg;
    logic [SIG_COUNT-1:0] hit;

    bss_match #(
        .HISTORY_BYTES (HISTORY_BYTES),
        .FW            (FW)
    ) u_match (
        .cur  (step.data),
        .hist (hist_reg),
        .fill (fill_reg),
        .hit  (hit)
    );

    // Mask including a signature that ends on this byte
    assign found = seen_reg | hit;

    // Saturating fill count
    assign fill_next = (fill_reg == FW'(HISTORY_BYTES)) ? fill_reg : fill_reg + FW'(1);

    // Shift in the byte, or clear everything after the last byte of a message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HISTORY_BYTES; k++)
            begin
                hist_reg[k] <= '0;
            end
            fill_reg <= '0;
            seen_reg <= '0;
        end
        else if (step.take)
        begin
            if (step.last)
            begin
                for (int k = 0; k < HISTORY_BYTES; k++)
                begin
                    hist_reg[k] <= '0;
                end
                fill_reg <= '0;
                seen_reg <= '0;
            end
            else
            begin
                hist_reg[0] <= step.data;
                for (int k = 1; k < HISTORY_BYTES; k++)
                begin
                    hist_reg[k] <= hist_reg[k-1];
                end
                fill_reg <= fill_next;
                seen_reg <= found;
            end
        end
    end

endmodule

FILE: rtl/byte_signature_scanner_core.sv
// Top level of the byte signature scanner: input register, window, result register.
// Depends on bss_pkg, bss_if, bss_window and bss_match.
//
//   channel  | modport       | word                         | when
//   ---------+---------------+------------------------------+---------------------------
//   msg      | bss_in_if     | data_byte, last_byte         | one word per message byte
//   result   | bss_out_if    | suspicious, found_mask       | one word per message
//
// One byte per cycle sustained unless a stalled result holds back a last byte; the
// compare against the history window lies between the input register and the
// window/result registers; a last byte's result loads once the result register is free.
// Reset clears the window, fill count, mask and all valid flags.
// A stalled result holds back the next last byte and what follows; prior bytes flow on.
module byte_signature_scanner_core #(
    parameter int HISTORY_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    bss_in_if.sink       msg,
    bss_out_if.source    result
);
    import bss_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_data_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    logic                 out_susp_reg;
    logic [SIG_COUNT-1:0] out_mask_reg;
    logic                 out_free;
    logic                 advance;
    logic                 take;
    bss_step_t            step;
    logic [SIG_COUNT-1:0] found;

    // Flow control
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign msg.ready = !in_valid_reg || advance;
    assign take      = msg.valid && msg.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= msg.data_byte;
            in_last_reg <= msg.last_byte;
        end
    end

    assign step = '{take: advance, last: in_last_reg, data: in_data_reg};

    bss_window #(
        .HISTORY_BYTES (HISTORY_BYTES)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .found (found)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_susp_reg <= |found;
            out_mask_reg <= found;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.suspicious = out_susp_reg;
    assign result.found_mask = out_mask_reg;

endmodule

FILE: rtl/bss_checker.sv
// Port-level checks of the byte signature scanner, bound to the top level.
// Depends on the ports of byte_signature_scanner_core only.
module bss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       msg_last,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_susp,
    input logic [7:0] res_mask
);
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       last_in;
    logic       res_out;

    assign last_in = msg_valid && msg_ready && msg_last;
    assign res_out = res_valid && res_ready;

    // Messages whose last byte went in but whose result has not gone out
    always_comb
    begin
        pending_next = pending_reg;
        if (last_in && !res_out)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!last_in && res_out)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result word only follows a last byte
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pending_reg != 2'd0))
        else $error("result word without a pending message");

    // At most two messages are in flight: input register and result register
    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many messages in flight");

    // Flag agrees with the mask
    a_flag_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_susp == (res_mask != 8'd0)))
        else $error("suspicious flag disagrees with found mask");

    // A stalled result word stays
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result word dropped while stalled");

endmodule

bind byte_signature_scanner_core bss_checker u_bss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_last  (msg.last_byte),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_susp  (result.suspicious),
    .res_mask  (result.found_mask)
);
